// ===== design/bta_pkg.sv =====
package bta_pkg;

	localparam int VALUE_W        = 31;
	localparam int DIGIT_BUF      = 10;
	localparam int MAX_DIGITS_DEF = 10;
	localparam int BCD_W          = 4;
	localparam int CHAR_W         = 6;
	localparam int COUNT_W        = 4;

	// Double dabble: value padded to a whole number of steps.
	localparam int BITS_PER_STEP  = 4;
	localparam int SHIFT_W        = 32;
	localparam int STEPS          = SHIFT_W / BITS_PER_STEP;
	localparam int STEP_W         = $clog2(STEPS);

	localparam logic [CHAR_W-1:0] ASCII_ZERO = CHAR_W'(48);

	typedef struct packed {
		logic idle;
		logic done;
		logic ovf;
	} conv_status_t;

endpackage

// ===== design/bta_cell.sv =====
module bta_cell (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  clear,
	input  logic                                  step,
	input  logic [bta_pkg::BITS_PER_STEP-1:0]     din,
	output logic [bta_pkg::BITS_PER_STEP-1:0]     dout,
	output logic [bta_pkg::BCD_W-1:0]             digit
);

	logic [bta_pkg::BCD_W-1:0] digit_q;
	logic [bta_pkg::BCD_W-1:0] digit_next;

	// Add-3 then shift, one bit per sub-step, MSB of din first.
	always_comb begin
		logic [bta_pkg::BCD_W-1:0] d;
		d = digit_q;
		dout = '0;
		for (int j = bta_pkg::BITS_PER_STEP - 1; j >= 0; j--) begin
			if (d >= bta_pkg::BCD_W'(5)) begin
				d = d + bta_pkg::BCD_W'(3);
			end
			dout[j] = d[bta_pkg::BCD_W-1];
			d = {d[bta_pkg::BCD_W-2:0], din[j]};
		end
		digit_next = d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			digit_q <= '0;
		end else if (clear) begin
			digit_q <= '0;
		end else if (step) begin
			digit_q <= digit_next;
		end
	end

	assign digit = digit_q;

endmodule

// ===== design/bta_conv.sv =====
module bta_conv #(
	parameter int NCELL = bta_pkg::DIGIT_BUF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   load,
	input  logic [bta_pkg::VALUE_W-1:0]            value,
	input  logic                                   release_done,
	output bta_pkg::conv_status_t                  status,
	output logic [NCELL-1:0][bta_pkg::BCD_W-1:0]   digits
);

	typedef enum logic [2:0] {
		C_IDLE = 3'b001,
		C_RUN  = 3'b010,
		C_DONE = 3'b100
	} conv_state_t;

	conv_state_t                             state_q;
	logic [bta_pkg::SHIFT_W-1:0]             sh_q;
	logic [bta_pkg::STEP_W-1:0]              step_cnt_q;
	logic                                    ovf_q;
	logic [NCELL:0][bta_pkg::BITS_PER_STEP-1:0] link;
	logic                                    run;

	assign run     = (state_q == C_RUN) && !load;
	assign link[0] = sh_q[bta_pkg::SHIFT_W-1 -: bta_pkg::BITS_PER_STEP];

	for (genvar i = 0; i < NCELL; i++) begin : g_cell
		bta_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.clear  (load),
			.step   (run),
			.din    (link[i]),
			.dout   (link[i+1]),
			.digit  (digits[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= C_IDLE;
			step_cnt_q <= '0;
			ovf_q      <= 1'b0;
		end else if (load) begin
			state_q    <= C_RUN;
			step_cnt_q <= '0;
			ovf_q      <= 1'b0;
		end else begin
			case (state_q)
				C_RUN: begin
					ovf_q      <= ovf_q | (|link[NCELL]);
					step_cnt_q <= step_cnt_q + bta_pkg::STEP_W'(1);
					if (step_cnt_q == bta_pkg::STEP_W'(bta_pkg::STEPS - 1)) begin
						state_q <= C_DONE;
					end
				end
				C_DONE: begin
					if (release_done) begin
						state_q <= C_IDLE;
					end
				end
				default: begin
					state_q <= C_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			sh_q <= {{(bta_pkg::SHIFT_W - bta_pkg::VALUE_W){1'b0}}, value};
		end else if (run) begin
			sh_q <= {sh_q[bta_pkg::SHIFT_W-bta_pkg::BITS_PER_STEP-1:0],
				{bta_pkg::BITS_PER_STEP{1'b0}}};
		end
	end

	assign status.idle = (state_q == C_IDLE);
	assign status.done = (state_q == C_DONE);
	assign status.ovf  = ovf_q;

endmodule

// ===== design/binary_to_ascii_decimal_top.sv =====
// Binary to decimal ASCII converter.
// Input channel: in_valid / in_stall with a 31-bit value. Output channel:
// out_valid / out_stall, one transaction per decimal digit, most significant
// first, no leading zeros (zero gives a single '0'). Each transaction carries
// the ASCII digit, the digit count of the run and a flag on the final digit.
// With MAX_DIGITS below the digit count only the low MAX_DIGITS digits appear.
// Conversion runs a row of BCD cells, 4 bits per cycle. The digits follow
// one per cycle while the output is not stalled, from a separate emitter.
// The next value is taken when the converter hands its digits to the
// emitter, so a value can be converting while the last one is emitted.
// A stalled output holds its transaction; the emitter then waits, and the
// input stalls once the converter holds a finished value.
// Reset clears all control state; no transaction is pending after reset.
module binary_to_ascii_decimal_top #(
	parameter int MAX_DIGITS = bta_pkg::MAX_DIGITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [bta_pkg::VALUE_W-1:0]         value,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [bta_pkg::CHAR_W-1:0]          digit_char,
	output logic [bta_pkg::COUNT_W-1:0]         digit_count,
	output logic                                last_digit
);

	localparam int NCELL = (MAX_DIGITS < bta_pkg::DIGIT_BUF) ? MAX_DIGITS : bta_pkg::DIGIT_BUF;
	localparam int PTR_W = (NCELL > 1) ? $clog2(NCELL) : 1;

	bta_pkg::conv_status_t                  conv_st;
	logic [NCELL-1:0][bta_pkg::BCD_W-1:0]   conv_digits;
	logic                                   xfer;
	logic                                   load;
	logic                                   out_load;
	logic [bta_pkg::COUNT_W-1:0]            cnt_calc;

	logic [NCELL-1:0][bta_pkg::BCD_W-1:0]   dig_q;
	logic                                   em_busy_q;
	logic [PTR_W-1:0]                       ptr_q;
	logic [bta_pkg::COUNT_W-1:0]            cnt_q;
	logic                                   out_valid_q;
	logic [bta_pkg::CHAR_W-1:0]             digit_char_q;
	logic [bta_pkg::COUNT_W-1:0]            digit_count_q;
	logic                                   last_digit_q;

	assign xfer     = conv_st.done && !em_busy_q;
	assign in_stall = !(conv_st.idle || xfer);
	assign load     = in_valid && !in_stall;
	assign out_load = em_busy_q && (!out_valid_q || !out_stall);

	bta_conv #(
		.NCELL (NCELL)
	) u_conv (
		.clk          (clk),
		.arst_n       (arst_n),
		.load         (load),
		.value        (value),
		.release_done (xfer),
		.status       (conv_st),
		.digits       (conv_digits)
	);

	// Significant digits; full width if digits fell off the top cell.
	always_comb begin
		cnt_calc = bta_pkg::COUNT_W'(1);
		for (int i = 0; i < NCELL; i++) begin
			if (conv_digits[i] != '0) begin
				cnt_calc = bta_pkg::COUNT_W'(i + 1);
			end
		end
		if (conv_st.ovf) begin
			cnt_calc = bta_pkg::COUNT_W'(NCELL);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			em_busy_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (xfer) begin
				em_busy_q <= 1'b1;
			end else if (out_load && ptr_q == '0) begin
				em_busy_q <= 1'b0;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (xfer) begin
			dig_q <= conv_digits;
			cnt_q <= cnt_calc;
			ptr_q <= PTR_W'(cnt_calc - bta_pkg::COUNT_W'(1));
		end else if (out_load) begin
			ptr_q <= ptr_q - PTR_W'(1);
		end
		if (out_load) begin
			digit_char_q  <= bta_pkg::ASCII_ZERO + bta_pkg::CHAR_W'(dig_q[ptr_q]);
			digit_count_q <= cnt_q;
			last_digit_q  <= (ptr_q == '0);
		end
	end

	assign out_valid   = out_valid_q;
	assign digit_char  = digit_char_q;
	assign digit_count = digit_count_q;
	assign last_digit  = last_digit_q;

	a_no_gap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !last_digit |=> out_valid)
		else $error("digit run broken before its last digit");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (digit_count != '0) && (digit_count <= bta_pkg::COUNT_W'(NCELL)))
		else $error("digit count out of range");

	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("converter took a value while converting");

endmodule
